// ===== hdl/sorted_min_priority_queue_unit_assert.svh =====
// Assertion macros shared by the queue checker.
`ifndef SORTED_MIN_PRIORITY_QUEUE_UNIT_ASSERT_SVH
`define SORTED_MIN_PRIORITY_QUEUE_UNIT_ASSERT_SVH

// Plain concurrent check, disabled while reset is held.
`define SMPQ_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition seen at one edge implies another at the next edge.
`define SMPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  `SMPQ_ASSERT(label, clk, rst_n, (ante) |=> (cons), msg)

`endif

// ===== hdl/smpq_pkg.sv =====
// Types and constants of the sorted minimum priority queue.
package smpq_pkg;

  localparam int DefaultCapacity = 16;
  localparam int KeyW            = 32;
  localparam int OccW            = 5;

  typedef enum logic {
    KIND_INSERT = 1'b0,
    KIND_REMOVE = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic                   kind;
    logic signed [KeyW-1:0] value;
  } in_t;

  typedef struct packed {
    logic [1:0]             status;
    logic signed [KeyW-1:0] removed_value;
    logic [OccW-1:0]        occupancy;
  } out_t;

  // Shift command broadcast to every cell of the chain.
  typedef struct packed {
    logic shift_in;   // insert the new key at its sorted place
    logic shift_out;  // drop the head and move everything one cell left
  } cell_op_t;

endpackage

// ===== hdl/smpq_cell.sv =====
// One storage cell of the sorted shift chain.
module smpq_cell
  import smpq_pkg::*;
(
  input  logic                   clk_i,
  input  cell_op_t               op_i,
  input  logic                   valid_i,
  input  logic signed [KeyW-1:0] key_i,
  input  logic                   left_keep_i,
  input  logic signed [KeyW-1:0] left_value_i,
  input  logic signed [KeyW-1:0] right_value_i,
  output logic                   keep_o,
  output logic signed [KeyW-1:0] value_o
);

  logic signed [KeyW-1:0] value_q, value_d;

  // A valid entry not above the new key stays where it is.
  assign keep_o  = valid_i && (value_q <= key_i);
  assign value_o = value_q;

  always_comb begin
    value_d = value_q;
    if (op_i.shift_in && !keep_o) begin
      value_d = left_keep_i ? key_i : left_value_i;
    end else if (op_i.shift_out) begin
      value_d = right_value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

endmodule

// ===== hdl/sorted_min_priority_queue_unit.sv =====
// Top level of the sorted minimum priority queue built as a shift chain of cells.
//
// Usage: an item (kind, value) is taken at a rising edge where start is high and
// busy is low. Kind insert places the value after every stored value less than or
// equal to it; kind remove takes out the smallest stored value. Busy is never
// raised, so an item may be offered in every cycle.
// Each item gives exactly one result in the next cycle: res_o is valid while done_o
// is high, for that single cycle only. The result carries the status (ok, remove
// on empty queue, insert on full queue), the removed value (zero unless a remove
// succeeded) and the occupancy after the item, as the low five bits of the count.
// Throughput is one item per cycle: every cell compares the new key against its
// own entry in parallel and shifts in the same cycle, so the only loop is the
// registered update of the cell row and the entry counter.
// The receiver cannot stall; a result not taken in its cycle is gone.
// Reset empties the queue by clearing the entry count; the cell contents are left
// as they are and are never read before they have been written again.
module sorted_min_priority_queue_unit
  import smpq_pkg::*;
#(
  parameter int CAPACITY = DefaultCapacity
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  in_t  item_i,
  output logic done_o,
  output out_t res_o
);

  localparam int CntW = $clog2(CAPACITY + 1);

  logic [CntW-1:0] count_q, count_d;
  logic            done_q;
  out_t            res_q, res_d;

  logic            accept;
  logic            is_insert;
  logic            full;
  logic            empty;
  cell_op_t        op;

  logic signed [KeyW-1:0] cell_value [CAPACITY];
  logic                   cell_keep  [CAPACITY];

  // The chain updates as a single registered step, so the block is always free.
  assign busy = 1'b0;

  assign accept    = start && !busy;
  assign is_insert = (item_i.kind == KIND_INSERT);
  assign full      = (count_q == CntW'(CAPACITY));
  assign empty     = (count_q == '0);

  // Rejected items leave the cell row untouched.
  assign op.shift_in  = accept && is_insert && !full;
  assign op.shift_out = accept && !is_insert && !empty;

  // Cell 0 sees a virtual left neighbour that always keeps, so it takes the key
  // whenever its own entry moves on. The last cell refills from itself on a
  // remove; that entry falls outside the count and is never read.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                   valid;
    logic                   left_keep;
    logic signed [KeyW-1:0] left_value;
    logic signed [KeyW-1:0] right_value;

    assign valid       = (CntW'(i) < count_q);
    assign left_keep   = (i == 0) ? 1'b1 : cell_keep[(i == 0) ? 0 : i - 1];
    assign left_value  = (i == 0) ? item_i.value : cell_value[(i == 0) ? 0 : i - 1];
    assign right_value = (i == CAPACITY - 1) ? cell_value[i]
                                             : cell_value[(i == CAPACITY - 1) ? i : i + 1];

    smpq_cell u_cell (
      .clk_i        (clk_i),
      .op_i         (op),
      .valid_i      (valid),
      .key_i        (item_i.value),
      .left_keep_i  (left_keep),
      .left_value_i (left_value),
      .right_value_i(right_value),
      .keep_o       (cell_keep[i]),
      .value_o      (cell_value[i])
    );
  end

  always_comb begin
    logic [CntW+OccW-1:0] count_ext;

    count_d = count_q;
    if (op.shift_in) begin
      count_d = count_q + CntW'(1);
    end else if (op.shift_out) begin
      count_d = count_q - CntW'(1);
    end

    count_ext = {{OccW{1'b0}}, count_d};

    res_d.status = ST_OK;
    if (is_insert && full) begin
      res_d.status = ST_FULL;
    end else if (!is_insert && empty) begin
      res_d.status = ST_EMPTY;
    end
    res_d.removed_value = op.shift_out ? cell_value[0] : '0;
    res_d.occupancy     = count_ext[OccW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      done_q  <= accept;
    end
  end

  // The result payload needs no reset: it is only looked at while done_o is high.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

// ===== hdl/smpq_checker.sv =====
// Port-level checker for the sorted minimum priority queue, with its bind.
`include "sorted_min_priority_queue_unit_assert.svh"

module smpq_checker
  import smpq_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input in_t  item_i,
  input logic done_o,
  input out_t res_o
);

  // Every accepted item yields its result in the following cycle.
  `SMPQ_ASSERT_NEXT(a_result_follows, clk_i, rst_ni, start && !busy, done_o, "result missing after accepted item")

  // No result appears without an item accepted the cycle before.
  `SMPQ_ASSERT_NEXT(a_no_spurious, clk_i, rst_ni, !(start && !busy), !done_o, "result without an accepted item")

  // A rejected item never reports a removed value.
  `SMPQ_ASSERT(a_removed_zero, clk_i, rst_ni, done_o && (res_o.status != ST_OK) |-> (res_o.removed_value == '0), "removed value not zero on a rejected item")

  // A remove on an empty queue leaves the queue empty.
  `SMPQ_ASSERT(a_empty_occ, clk_i, rst_ni, done_o && (res_o.status == ST_EMPTY) |-> (res_o.occupancy == '0), "empty status with non-zero occupancy")

endmodule

bind sorted_min_priority_queue_unit smpq_checker u_smpq_checker (.*);
